[rtl/cfm_pkg.sv]
// Package for the truncating floating-point multiplier.
// Field widths, result kind codes and the shared pipeline payload type.
package cfm_pkg;
    localparam int EXP_BITS  = 8;
    localparam int FRAC_BITS = 24;
    localparam int MANT_BITS = FRAC_BITS + 1;
    localparam int PROD_BITS = 2 * MANT_BITS;
    localparam int EXPW_BITS = EXP_BITS + 2;
    // one partial product row per cell, 4 multiplier bits per row
    localparam int DIGIT_BITS = 4;
    localparam int NUM_CELLS  = (MANT_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PADB_BITS  = NUM_CELLS * DIGIT_BITS;
    // the finished accumulator holds the product shifted down by this many bits
    localparam int ACC_DROP   = PADB_BITS - MANT_BITS;

    localparam logic [EXP_BITS-1:0] EXP_ONES = {EXP_BITS{1'b1}};
    localparam logic [EXPW_BITS-1:0] EXP_BIAS =
        EXPW_BITS'((1 << (EXP_BITS - 1)) - 1);

    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_ZERO   = 2'd1;
    localparam logic [1:0] KIND_INF    = 2'd2;
    localparam logic [1:0] KIND_NAN    = 2'd3;

    typedef struct packed {
        logic                  special;
        logic                  sign;
        logic [EXP_BITS-1:0]   exp;
        logic [FRAC_BITS-1:0]  frac;
        logic [1:0]            kind;
        logic                  sr;
        logic [EXPW_BITS-1:0]  esum;
        logic [MANT_BITS-1:0]  ma;
        logic [PADB_BITS-1:0]  mb;
        logic [PROD_BITS-1:0]  acc;
    } cfm_data_t;
endpackage

[rtl/cfm_if.sv]
// Valid/ready channel interfaces for operand pairs and products.
// Depends on cfm_pkg for widths.
interface cfm_in_if;
    import cfm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 a_sign;
    logic [EXP_BITS-1:0]  a_exp;
    logic [FRAC_BITS-1:0] a_frac;
    logic                 b_sign;
    logic [EXP_BITS-1:0]  b_exp;
    logic [FRAC_BITS-1:0] b_frac;
    modport source (output valid, a_sign, a_exp, a_frac, b_sign, b_exp, b_frac,
                    input ready);
    modport sink (input valid, a_sign, a_exp, a_frac, b_sign, b_exp, b_frac,
                  output ready);
endinterface

interface cfm_out_if;
    import cfm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 r_sign;
    logic [EXP_BITS-1:0]  r_exp;
    logic [FRAC_BITS-1:0] r_frac;
    logic [1:0]           r_kind;
    logic                 range_flag;
    modport source (output valid, r_sign, r_exp, r_frac, r_kind, range_flag,
                    input ready);
    modport sink (input valid, r_sign, r_exp, r_frac, r_kind, range_flag,
                  output ready);
endinterface

[rtl/custom_float_multiplier.sv]
// Top level of the truncating floating-point multiplier.
// Depends on cfm_pkg, cfm_if and cfm_cell.
//
// channel | dir | contents
// in      | in  | a_sign a_exp a_frac b_sign b_exp b_frac
// out     | out | r_sign r_exp r_frac r_kind range_flag
//
// One pair accepted per cycle while the pipeline is not held; each pair
// passes through the row of multiply cells and then the normalise
// register; decode is combinational ahead of the first cell. Reset empties
// the pipeline. The whole pipeline holds while out.valid is high and
// out.ready low.
module custom_float_multiplier (
    input logic clk,
    input logic rst_n,
    cfm_in_if.sink    in,
    cfm_out_if.source out
);
    import cfm_pkg::*;

    logic      advance;
    logic      valid_c [NUM_CELLS+1];
    cfm_data_t data_c  [NUM_CELLS+1];
    cfm_data_t dec_next;
    logic      a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic      carry;
    logic [EXPW_BITS-1:0] e_fin;
    logic [FRAC_BITS-1:0] frac_n;
    logic                 osign_next, oflag_next;
    logic [EXP_BITS-1:0]  oexp_next;
    logic [FRAC_BITS-1:0] ofrac_next;
    logic [1:0]           okind_next;
    logic                 ovalid_reg;
    logic                 osign_reg, oflag_reg;
    logic [EXP_BITS-1:0]  oexp_reg;
    logic [FRAC_BITS-1:0] ofrac_reg;
    logic [1:0]           okind_reg;

    assign advance  = !ovalid_reg || out.ready;
    assign in.ready = advance;

    always_comb
    begin
        a_zero = (in.a_exp == '0) && (in.a_frac == '0);
        b_zero = (in.b_exp == '0) && (in.b_frac == '0);
        a_inf  = (in.a_exp == EXP_ONES) && (in.a_frac == '0);
        b_inf  = (in.b_exp == EXP_ONES) && (in.b_frac == '0);
        a_nan  = (in.a_exp == EXP_ONES) && (in.a_frac != '0);
        b_nan  = (in.b_exp == EXP_ONES) && (in.b_frac != '0);
        dec_next         = '0;
        dec_next.sr      = in.a_sign ^ in.b_sign;
        dec_next.esum    = EXPW_BITS'(in.a_exp) + EXPW_BITS'(in.b_exp);
        dec_next.ma      = {1'b1, in.a_frac};
        dec_next.mb      = PADB_BITS'({1'b1, in.b_frac});
        dec_next.special = 1'b1;
        if (a_nan || b_nan || (a_zero && b_inf) || (a_inf && b_zero))
        begin
            dec_next.sign = 1'b1;
            dec_next.exp  = EXP_ONES;
            dec_next.frac = FRAC_BITS'(1);
            dec_next.kind = KIND_NAN;
        end
        else if (a_zero || b_zero)
            dec_next.kind = KIND_ZERO;
        else if (a_inf || b_inf)
        begin
            dec_next.sign = dec_next.sr;
            dec_next.exp  = EXP_ONES;
            dec_next.kind = KIND_INF;
        end
        else
            dec_next.special = 1'b0;
    end

    assign valid_c[0] = in.valid;
    assign data_c[0]  = dec_next;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        cfm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (valid_c[i]),
            .data_in   (data_c[i]),
            .valid_out (valid_c[i+1]),
            .data_out  (data_c[i+1])
        );
    end

    always_comb
    begin
        cfm_data_t d;
        d      = data_c[NUM_CELLS];
        carry  = d.acc[PROD_BITS-1-ACC_DROP];
        frac_n = carry ? d.acc[PROD_BITS-2-ACC_DROP -: FRAC_BITS]
                       : d.acc[PROD_BITS-3-ACC_DROP -: FRAC_BITS];
        // esum - bias + carry, evaluated as signed over the extended width
        e_fin  = d.esum - EXP_BIAS + EXPW_BITS'(carry);
        osign_next = d.sign;
        oexp_next  = d.exp;
        ofrac_next = d.frac;
        okind_next = d.kind;
        oflag_next = 1'b0;
        if (!d.special)
        begin
            if (!e_fin[EXPW_BITS-1] && (e_fin >= EXPW_BITS'(EXP_ONES)))
            begin
                osign_next = d.sr;
                oexp_next  = EXP_ONES;
                ofrac_next = '0;
                okind_next = KIND_INF;
                oflag_next = 1'b1;
            end
            else if (e_fin[EXPW_BITS-1] || (e_fin == '0))
            begin
                osign_next = 1'b0;
                oexp_next  = '0;
                ofrac_next = '0;
                okind_next = KIND_ZERO;
                oflag_next = 1'b1;
            end
            else
            begin
                osign_next = d.sr;
                oexp_next  = e_fin[EXP_BITS-1:0];
                ofrac_next = frac_n;
                okind_next = KIND_NORMAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (advance)
            ovalid_reg <= valid_c[NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            osign_reg <= osign_next;
            oexp_reg  <= oexp_next;
            ofrac_reg <= ofrac_next;
            okind_reg <= okind_next;
            oflag_reg <= oflag_next;
        end
    end

    assign out.valid      = ovalid_reg;
    assign out.r_sign     = osign_reg;
    assign out.r_exp      = oexp_reg;
    assign out.r_frac     = ofrac_reg;
    assign out.r_kind     = okind_reg;
    assign out.range_flag = oflag_reg;

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> $stable(out.r_exp) && $stable(out.r_kind))
        else $error("result changed while stalled");
    a_flag_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.range_flag) |->
            (out.r_kind == KIND_INF || out.r_kind == KIND_ZERO))
        else $error("range flag on wrong kind");
    a_nan_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.r_kind == KIND_NAN) |->
            (out.r_exp == EXP_ONES && out.r_sign && !out.range_flag))
        else $error("malformed NaN");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out.valid |-> in.ready)
        else $error("input stalled with empty output");
endmodule

[rtl/cfm_cell.sv]
// One multiplier cell: adds the partial product row of one 4-bit digit of b and passes on.
// Depends on cfm_pkg.
module cfm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               valid_in,
    input  cfm_pkg::cfm_data_t data_in,
    output logic               valid_out,
    output cfm_pkg::cfm_data_t data_out
);
    import cfm_pkg::*;
    logic [PROD_BITS-1:0] row;
    cfm_data_t            data_next;
    logic                 valid_reg;
    cfm_data_t            data_reg;

    always_comb
    begin
        row = PROD_BITS'(data_in.ma) * PROD_BITS'(data_in.mb[DIGIT_BITS-1:0]);
        data_next     = data_in;
        // consume the low digit of b; weight of the remaining digits shifts down
        data_next.ma  = data_in.ma;
        data_next.mb  = data_in.mb >> DIGIT_BITS;
        data_next.acc = (data_in.acc >> DIGIT_BITS)
                        + (row << (PROD_BITS - DIGIT_BITS - MANT_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
endmodule

[bench/tb_custom_float_multiplier.sv]
// Self-checking bench for the truncating floating-point multiplier.
// Depends on cfm_pkg and cfm_if; drives operand pairs and checks products.
`timescale 1ns / 100ps

module tb_custom_float_multiplier;
    import cfm_pkg::*;

    typedef struct packed {
        logic                 sign;
        logic [EXP_BITS-1:0]  exp;
        logic [FRAC_BITS-1:0] frac;
        logic [1:0]           kind;
        logic                 flag;
    } product_t;

    localparam int LATENCY = NUM_CELLS + 2;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    cfm_in_if  in_ch ();
    cfm_out_if out_ch ();

    custom_float_multiplier dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    product_t  expected_products[$];
    int        error_count;
    int        product_count;
    int        cycle_count;
    bit        idle_enable;
    int        hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count <= cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t timeout", $time);
                $display("tb_custom_float_multiplier: errors");
                $finish;
            end
        end
    end

    // Predict one product from the operand fields.
    function automatic product_t multiply_truncated(
        logic sa, logic [EXP_BITS-1:0] ea, logic [FRAC_BITS-1:0] fa,
        logic sb, logic [EXP_BITS-1:0] eb, logic [FRAC_BITS-1:0] fb);
        product_t              p;
        logic [PROD_BITS-1:0]  prod;
        logic                  carry;
        logic                  sr;
        bit                    za, zb, ia, ib, na, nb;
        int                    e;
        sr = sa ^ sb;
        za = (ea == '0) && (fa == '0);
        zb = (eb == '0) && (fb == '0);
        ia = (ea == EXP_ONES) && (fa == '0);
        ib = (eb == EXP_ONES) && (fb == '0);
        na = (ea == EXP_ONES) && (fa != '0);
        nb = (eb == EXP_ONES) && (fb != '0);
        if (na || nb || (za && ib) || (ia && zb))
            return '{1'b1, EXP_ONES, FRAC_BITS'(1), KIND_NAN, 1'b0};
        if (za || zb)
            return '{1'b0, '0, '0, KIND_ZERO, 1'b0};
        if (ia || ib)
            return '{sr, EXP_ONES, '0, KIND_INF, 1'b0};
        prod = PROD_BITS'({1'b1, fa}) * PROD_BITS'({1'b1, fb});
        carry = prod[PROD_BITS-1];
        p.frac = carry ? prod[2*FRAC_BITS -: FRAC_BITS]
                       : prod[2*FRAC_BITS-1 -: FRAC_BITS];
        e = int'(ea) + int'(eb) - int'(EXP_BIAS) + int'(carry);
        if (e >= int'(EXP_ONES))
            return '{sr, EXP_ONES, '0, KIND_INF, 1'b1};
        if (e <= 0)
            return '{1'b0, '0, '0, KIND_ZERO, 1'b1};
        p.sign = sr;
        p.exp = EXP_BITS'(e);
        p.kind = KIND_NORMAL;
        p.flag = 1'b0;
        return p;
    endfunction

    // Offer one pair, with optional idle burst first, and wait for the transfer.
    task automatic send_pair(logic sa, logic [EXP_BITS-1:0] ea, logic [FRAC_BITS-1:0] fa,
                             logic sb, logic [EXP_BITS-1:0] eb, logic [FRAC_BITS-1:0] fb);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.a_sign <= sa;
        in_ch.a_exp  <= ea;
        in_ch.a_frac <= fa;
        in_ch.b_sign <= sb;
        in_ch.b_exp  <= eb;
        in_ch.b_frac <= fb;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_products = {expected_products,
                             multiply_truncated(sa, ea, fa, sb, eb, fb)};
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (expected_products.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // Check each product as it transfers.
    initial
    begin
        product_t got;
        product_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.r_sign, out_ch.r_exp, out_ch.r_frac,
                        out_ch.r_kind, out_ch.range_flag};
                if (expected_products.size() == 0)
                begin
                    $display("%0t unexpected product %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    product_count++;
                    if (got.sign !== want.sign)
                    begin
                        $display("%0t r_sign exp %h got %h", $time, want.sign, got.sign);
                        error_count++;
                    end
                    if (got.exp !== want.exp)
                    begin
                        $display("%0t r_exp exp %h got %h", $time, want.exp, got.exp);
                        error_count++;
                    end
                    if (got.frac !== want.frac)
                    begin
                        $display("%0t r_frac exp %h got %h", $time, want.frac, got.frac);
                        error_count++;
                    end
                    if (got.kind !== want.kind)
                    begin
                        $display("%0t r_kind exp %h got %h", $time, want.kind, got.kind);
                        error_count++;
                    end
                    if (got.flag !== want.flag)
                    begin
                        $display("%0t range_flag exp %h got %h", $time, want.flag,
                                 got.flag);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, or a long hold-off when requested.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                out_ch.ready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall = $urandom_range(1, 6);
                repeat (stall - 1) @(posedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [EXP_BITS-1:0] pick_exp();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return EXP_ONES;
            2: return EXP_BITS'($urandom_range(1, 6));
            3: return EXP_BITS'($urandom_range(248, 254));
            default: return EXP_BITS'($urandom_range(64, 190));
        endcase
    endfunction

    function automatic logic [FRAC_BITS-1:0] pick_frac();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return FRAC_BITS'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [EXP_BITS-1:0] mid;
        mid = EXP_BIAS[EXP_BITS-1:0];
        send_pair(1'b0, mid, '0, 1'b0, mid, '0);             // one times one
        send_pair(1'b1, mid, '1, 1'b0, mid, '1);             // carry out of the product
        send_pair(1'b0, '0, '0, 1'b1, mid, 24'h123456);      // zero operand
        send_pair(1'b1, mid, 24'h5, 1'b1, '0, '0);
        send_pair(1'b0, '0, '0, 1'b0, EXP_ONES, '0);         // zero times infinity
        send_pair(1'b1, EXP_ONES, '0, 1'b0, '0, '0);
        send_pair(1'b1, EXP_ONES, '0, 1'b0, mid, 24'h7);     // infinite operand
        send_pair(1'b1, EXP_ONES, '0, 1'b1, EXP_ONES, '0);
        send_pair(1'b0, EXP_ONES, 24'h1, 1'b0, mid, '0);     // NaN operands
        send_pair(1'b1, mid, '0, 1'b1, EXP_ONES, '1);
        send_pair(1'b0, '0, 24'h800000, 1'b0, mid, '0);      // denormal taken as normalised
        send_pair(1'b1, '0, '1, 1'b0, 8'd200, '1);
        send_pair(1'b0, 8'd254, '1, 1'b1, 8'd254, '1);       // overflow
        send_pair(1'b0, 8'd191, '0, 1'b0, 8'd191, '0);       // exactly all ones
        send_pair(1'b0, 8'd190, '1, 1'b0, 8'd191, '0);       // largest finite exponent, no carry
        send_pair(1'b1, 8'd1, '0, 1'b0, 8'd1, '0);           // underflow
        send_pair(1'b0, 8'd63, '0, 1'b0, 8'd64, '0);         // exponent exactly zero
        send_pair(1'b0, 8'd63, '1, 1'b0, 8'd64, '1);         // carry lifts it to one
        send_pair(1'b1, 8'd128, '0, 1'b1, 8'd126, '0);       // exponent 127
        send_pair(1'b0, 8'd254, '0, 1'b1, 8'd1, '1);
        stop_sending();
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_pair(1'($urandom_range(0, 1)), pick_exp(), pick_frac(),
                      1'($urandom_range(0, 1)), pick_exp(), pick_frac());
        stop_sending();
    endtask

    // Hold off the receiver while pairs keep coming so the pipeline stalls its input.
    task automatic test_backpressure();
        hold_off_cycles = 60;
        test_random(40);
    endtask

    initial
    begin
        error_count = 0;
        product_count = 0;
        idle_enable = 1'b1;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.a_sign = 1'b0;
        in_ch.a_exp = '0;
        in_ch.a_frac = '0;
        in_ch.b_sign = 1'b0;
        in_ch.b_exp = '0;
        in_ch.b_frac = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250);
        // pause until everything has drained before continuing
        wait_drained();
        test_backpressure();
        test_random(200);
        idle_enable = 1'b0;
        test_random(140);

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        $display("Checked %0d products: specials, range edges, random operands,",
                 product_count);
        $display("input stalls under a long output hold-off and gap-free streaming.");
        if (error_count == 0 && expected_products.size() == 0)
            $display("tb_custom_float_multiplier: clean");
        else
            $display("tb_custom_float_multiplier: errors");
        $finish;
    end
endmodule
